FILE: hdl/hcb_pkg.sv
// Shared constants, types and widths for the HSV color blend pipeline.
`default_nettype none
package hcb_pkg;

    localparam int CB        = 8;
    localparam int HF        = 8;
    localparam int HW        = HF + 3;
    localparam int KW        = HF + 1;
    localparam int RSH       = 24;
    localparam int RW        = RSH + 1;
    localparam int NSTG      = 7;
    localparam logic [CB-1:0] CMAX      = CB'((1 << CB) - 1);
    localparam logic [KW-1:0] BLEND_ONE = KW'(1 << HF);
    localparam logic [HW-1:0] HUNIT     = HW'(1 << HF);
    localparam logic [HW-1:0] HTURN     = HW'(6 << HF);
    localparam logic [2*CB-1:0] HSCALE  = (2*CB)'(((1 << CB) - 1) << HF);
    localparam logic [RW-1:0] R255      = RW'(((1 << RSH) + 254) / 255);

    typedef struct packed {
        logic [HW-1:0] h;
        logic [CB-1:0] s;
        logic [CB-1:0] v;
        logic          def;
    } hcb_hsv_t;

    typedef enum logic [1:0] {
        MODE_HUE,
        MODE_GRAY,
        MODE_BLACK
    } hcb_mode_t;

endpackage
`default_nettype wire

FILE: hdl/hcb_to_hsv.sv
// Two-stage RGB to HSV conversion with reciprocal-table division.
`default_nettype none
module hcb_to_hsv
    import hcb_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic [1:0]      stage_en,
    input  wire logic [CB-1:0]   red,
    input  wire logic [CB-1:0]   green,
    input  wire logic [CB-1:0]   blue,
    output hcb_hsv_t             hsv
);

    logic [RW-1:0] rtab [256];

    assign rtab[0] = '0;
    for (genvar i = 1; i < 256; i++) begin : g_rcp
        localparam logic [RW-1:0] RCP = RW'(((1 << RSH) + i - 1) / i);
        assign rtab[i] = RCP;
    end

    logic [CB-1:0] mx, mn, dd;
    logic [HW-1:0] base;
    logic          neg;

    logic [CB-1:0] mx_reg, dl_reg, d_reg;
    logic [HW-1:0] base_reg;
    logic          neg_reg;

    always_comb begin
        mx = red;
        mn = red;
        if (green > mx) mx = green;
        if (blue > mx) mx = blue;
        if (green < mn) mn = green;
        if (blue < mn) mn = blue;
        priority if (red == mx) begin
            neg  = (green < blue);
            base = neg ? HTURN : '0;
            dd   = neg ? blue - green : green - blue;
        end else if (green == mx) begin
            base = HW'(2 << HF);
            neg  = (blue < red);
            dd   = neg ? red - blue : blue - red;
        end else begin
            base = HW'(4 << HF);
            neg  = (red < green);
            dd   = neg ? green - red : red - green;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            mx_reg   <= mx;
            dl_reg   <= mx - mn;
            d_reg    <= dd;
            base_reg <= base;
            neg_reg  <= neg;
        end
    end

    logic [2*CB-1:0] sn, hn;
    logic [40:0]     sp, hp;
    logic [HF:0]     hq;
    logic [HW:0]     hs;
    hcb_hsv_t        hsv_next, hsv_reg;

    always_comb begin
        sn = {dl_reg, CB'(0)} - (2*CB)'(dl_reg);
        hn = {d_reg, HF'(0)};
        sp = 41'(sn) * 41'(rtab[mx_reg]);
        hp = 41'(hn) * 41'(rtab[dl_reg]);
        hq = hp[RSH+HF:RSH];
        hs = neg_reg ? {1'b0, base_reg} - (HW+1)'(hq) : {1'b0, base_reg} + (HW+1)'(hq);
        hsv_next.v   = mx_reg;
        hsv_next.def = (dl_reg != '0);
        if (dl_reg == '0) begin
            hsv_next.s = '0;
            hsv_next.h = '0;
        end else begin
            hsv_next.s = sp[RSH+CB-1:RSH];
            hsv_next.h = (hs >= (HW+1)'(HTURN)) ? '0 : hs[HW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            hsv_reg <= hsv_next;
        end
    end

    assign hsv = hsv_reg;

endmodule
`default_nettype wire

FILE: hdl/hcb_mix.sv
// Linear interpolation of two HSV colors by the blend factor.
`default_nettype none
module hcb_mix
    import hcb_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          stage_en,
    input  wire hcb_hsv_t      hsv_a,
    input  wire hcb_hsv_t      hsv_b,
    input  wire logic [KW-1:0] blend,
    output hcb_hsv_t           hsv
);

    function automatic logic [HW-1:0] mixf(logic [HW-1:0] x, logic [HW-1:0] y,
                                           logic [KW-1:0] k);
        logic signed [HW:0]      df;
        logic signed [HW+KW:0]   pr;
        logic signed [HW+KW:0]   qt;
        df = $signed({1'b0, y}) - $signed({1'b0, x});
        pr = df * $signed({1'b0, k});
        qt = (pr < 0) ? (pr + (HW+KW+1)'(255)) >>> HF : pr >>> HF;
        mixf = x + qt[HW-1:0];
    endfunction

    hcb_hsv_t      hsv_next, hsv_reg;
    logic [HW-1:0] sm, vm;

    always_comb begin
        sm = mixf(HW'(hsv_a.s), HW'(hsv_b.s), blend);
        vm = mixf(HW'(hsv_a.v), HW'(hsv_b.v), blend);
        hsv_next.h   = mixf(hsv_a.h, hsv_b.h, blend);
        hsv_next.s   = sm[CB-1:0];
        hsv_next.v   = vm[CB-1:0];
        hsv_next.def = hsv_a.def && hsv_b.def;
    end

    always_ff @(posedge aclk) begin
        if (stage_en) begin
            hsv_reg <= hsv_next;
        end
    end

    assign hsv = hsv_reg;

endmodule
`default_nettype wire

FILE: hdl/hcb_to_rgb.sv
// Four-stage HSV to RGB conversion by the six-sector rule.
`default_nettype none
module hcb_to_rgb
    import hcb_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic [3:0]    stage_en,
    input  wire hcb_hsv_t      hsv,
    output logic [CB-1:0]      red,
    output logic [CB-1:0]      green,
    output logic [CB-1:0]      blue
);

    logic [HF-1:0]   f;
    logic [HF:0]     fc;
    logic [2*CB-1:0] sf;
    logic [2*CB:0]   sfc;
    hcb_mode_t       mode;

    logic [CB-1:0]   v4_reg, v5_reg, v6_reg;
    logic [2:0]      sec4_reg, sec5_reg, sec6_reg;
    hcb_mode_t       mode4_reg, mode5_reg, mode6_reg;
    logic [2*CB-1:0] qa_reg, ta_reg, pn_reg;
    logic [3*CB-1:0] qn_reg, tn_reg;
    logic [CB-1:0]   p5_reg, p6_reg, q6_reg, t6_reg;
    logic [CB-1:0]   r_reg, g_reg, b_reg;

    always_comb begin
        f   = hsv.h[HF-1:0];
        fc  = (HF+1)'(HUNIT) - (HF+1)'(f);
        sf  = (2*CB)'(hsv.s * f);
        sfc = (2*CB+1)'(hsv.s * fc);
        priority if (!hsv.def) begin
            mode = MODE_GRAY;
        end else if (hsv.s == '0) begin
            mode = MODE_BLACK;
        end else begin
            mode = MODE_HUE;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            v4_reg    <= hsv.v;
            sec4_reg  <= hsv.h[HW-1:HF];
            mode4_reg <= mode;
            qa_reg    <= HSCALE - sf;
            ta_reg    <= HSCALE - sfc[2*CB-1:0];
            pn_reg    <= (2*CB)'(hsv.v * (CMAX - hsv.s));
        end
    end

    logic [40:0] pp, qp, tp;

    assign pp = 41'(pn_reg) * 41'(R255);

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            v5_reg    <= v4_reg;
            sec5_reg  <= sec4_reg;
            mode5_reg <= mode4_reg;
            qn_reg    <= (3*CB)'(v4_reg * qa_reg);
            tn_reg    <= (3*CB)'(v4_reg * ta_reg);
            p5_reg    <= pp[RSH+CB-1:RSH];
        end
    end

    assign qp = 41'(qn_reg[3*CB-1:HF]) * 41'(R255);
    assign tp = 41'(tn_reg[3*CB-1:HF]) * 41'(R255);

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            v6_reg    <= v5_reg;
            sec6_reg  <= sec5_reg;
            mode6_reg <= mode5_reg;
            p6_reg    <= p5_reg;
            q6_reg    <= qp[RSH+CB-1:RSH];
            t6_reg    <= tp[RSH+CB-1:RSH];
        end
    end

    logic [CB-1:0] r_next, g_next, b_next;

    always_comb begin
        unique case (mode6_reg)
            MODE_GRAY: begin
                r_next = v6_reg;
                g_next = v6_reg;
                b_next = v6_reg;
            end
            MODE_BLACK: begin
                r_next = '0;
                g_next = '0;
                b_next = '0;
            end
            default: begin
                unique case (sec6_reg)
                    3'd0: begin
                        r_next = v6_reg; g_next = t6_reg; b_next = p6_reg;
                    end
                    3'd1: begin
                        r_next = q6_reg; g_next = v6_reg; b_next = p6_reg;
                    end
                    3'd2: begin
                        r_next = p6_reg; g_next = v6_reg; b_next = t6_reg;
                    end
                    3'd3: begin
                        r_next = p6_reg; g_next = q6_reg; b_next = v6_reg;
                    end
                    3'd4: begin
                        r_next = t6_reg; g_next = p6_reg; b_next = v6_reg;
                    end
                    default: begin
                        r_next = v6_reg; g_next = p6_reg; b_next = q6_reg;
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            r_reg <= r_next;
            g_reg <= g_next;
            b_reg <= b_next;
        end
    end

    assign red   = r_reg;
    assign green = g_reg;
    assign blue  = b_reg;

endmodule
`default_nettype wire

FILE: hdl/hsv_color_blend.sv
// Top level: blends two RGB colors through HSV space, one word per clock while the output is taken.
//
//  channel | direction | tdata fields (low bit first)
//  s_      | in        | a_red, a_green, a_blue, b_red, b_green, b_blue, blend
//  m_      | out       | out_red, out_green, out_blue
//
// The stages run in order: conversion of both colors to HSV, the mix, and
// conversion back to RGB, each stage registered.
// One word enters per clock when the output is taken every clock.
// Each stage advances when empty or when the stage after it advances, so
// bubbles fill and a stall loses no word. Reset clears only the valid bits.
`default_nettype none
module hsv_color_blend
    import hcb_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,  // a_red, a_green, a_blue, b_red, b_green, b_blue, blend
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata   // out_red, out_green, out_blue
);

    logic [NSTG-1:0] vld_reg, vld_next, en;
    logic [KW-1:0]   k_in, k1_reg, k2_reg;
    hcb_hsv_t        hsv_a, hsv_b, hsv_m;
    logic [CB-1:0]   out_r, out_g, out_b;

    always_comb begin
        en[NSTG-1] = !vld_reg[NSTG-1] || m_tready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
        vld_next[0] = en[0] ? s_tvalid : vld_reg[0];
        for (int i = 1; i < NSTG; i++) begin
            vld_next[i] = en[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign k_in = (s_tdata[56:48] > BLEND_ONE) ? BLEND_ONE : s_tdata[56:48];

    always_ff @(posedge aclk) begin
        if (en[0]) k1_reg <= k_in;
        if (en[1]) k2_reg <= k1_reg;
    end

    hcb_to_hsv u_hsv_a (
        .aclk     (aclk),
        .stage_en (en[1:0]),
        .red      (s_tdata[7:0]),
        .green    (s_tdata[15:8]),
        .blue     (s_tdata[23:16]),
        .hsv      (hsv_a)
    );

    hcb_to_hsv u_hsv_b (
        .aclk     (aclk),
        .stage_en (en[1:0]),
        .red      (s_tdata[31:24]),
        .green    (s_tdata[39:32]),
        .blue     (s_tdata[47:40]),
        .hsv      (hsv_b)
    );

    hcb_mix u_mix (
        .aclk     (aclk),
        .stage_en (en[2]),
        .hsv_a    (hsv_a),
        .hsv_b    (hsv_b),
        .blend    (k2_reg),
        .hsv      (hsv_m)
    );

    hcb_to_rgb u_rgb (
        .aclk     (aclk),
        .stage_en (en[6:3]),
        .hsv      (hsv_m),
        .red      (out_r),
        .green    (out_g),
        .blue     (out_b)
    );

    assign s_tready = en[0];
    assign m_tvalid = vld_reg[NSTG-1];
    assign m_tdata  = {out_b, out_g, out_r};

endmodule
`default_nettype wire

FILE: hdl/hcb_checker.sv
// Port-level checks on the blend pipeline, bound to the top level.
`default_nettype none
module hcb_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_drain_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input blocked while output drains");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && m_tready ##1 m_tready ##1 m_tready ##1 m_tready
        ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("word not delivered within seven cycles");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output word changed");

endmodule

bind hsv_color_blend hcb_checker u_hcb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
